### src/tcce_pkg.sv
// shared types and constants of the text console cell engine
package tcce_pkg;

  // default store geometry
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 128;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b1;
  localparam logic [7:0] COLUMN_COUNT_RST = 8'd80;
  localparam logic [6:0] ROW_COUNT_RST    = 7'd25;

  // cell contents
  localparam int CELL_W = 7;
  localparam logic [CELL_W-1:0] BLANK_CELL = 7'h20;

  // operations
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // console bytes
  localparam logic [7:0] ESC_BYTE  = 8'd27;
  localparam logic [7:0] LBRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_J    = 8'h4A;
  localparam logic [7:0] CHAR_H    = 8'h48;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_BS   = 8'h08;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  // escape phases
  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_SEEN   = 2'd1;
  localparam logic [1:0] ESC_CSI    = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
    logic [5:0] read_row;
    logic [6:0] read_column;
  } in_t;

  typedef struct packed {
    logic [6:0] cell_char;
    logic [5:0] cursor_row;
    logic [6:0] cursor_column;
    logic [1:0] escape_phase;
  } out_t;

endpackage

### src/tcce_ram.sv
// generic single port ram with registered read
module tcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/text_console_cell_engine.sv
// top level of the text console cell engine
//
// Character terminal engine. Each input beat either feeds one console byte
// (op 0) or reads one cell of the character store (op 1); every beat gives
// exactly one result beat carrying the cell read (0 for a byte feed), the
// cursor after the beat and the escape phase. The store is MAX_ROWS x
// MAX_COLUMNS cells of 7 bits in one single port ram, and all store traffic
// goes through one shared address unit (row * MAX_COLUMNS + column, or the
// clearing counter) under a small sequencer; the block takes one beat at a
// time. A new line below the last row in use scrolls the area in use
// through the single ram port, one read and one write per cell (the last
// row is only written with blanks). ESC [ digits J or H blanks the whole
// store, one cell a cycle. After reset the same clearing pass runs before
// the first input beat is taken; configuration writes are taken at any
// time. A finished result waits in an output register, so the next beat
// can be taken while it is still pending.
module text_console_cell_engine
  import tcce_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_SCR_RD = 6'b000100,
    ST_SCR_WR = 6'b001000,
    ST_WIPE   = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [7:0] col_count_r;
  logic [6:0] row_count_r;
  logic [CCNT_W-1:0] cols;
  logic [RCNT_W-1:0] rows;

  // cursor and escape state
  logic [ROW_W-1:0] crow_r, crow_nxt, crow_s;
  logic [COL_W-1:0] ccol_r, ccol_nxt, ccol_s;
  logic [1:0]       esc_r, esc_nxt;

  // sequencer counters
  logic [ROW_W-1:0]  scr_y_r, scr_y_nxt;
  logic [COL_W-1:0]  scr_x_r, scr_x_nxt;
  logic [ADDR_W-1:0] wipe_cnt_r, wipe_cnt_nxt;
  logic              wipe_resp_r, wipe_resp_nxt;
  logic              rd_blank_r, rd_blank_nxt;

  // held beat and result register
  in_t  item_r;
  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, load_out;

  // shared address unit and ram port
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic              sweep;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we, ram_re;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // helpers
  logic [RCNT_W-1:0] crow_inc, scr_y_inc;
  logic [CCNT_W-1:0] ccol_inc;
  logic              row_fits, scr_last_row, scr_last_col, rd_in_range;
  logic              is_brk, fin;
  logic [7:0]        ch;

  assign ch = item_r.char_in;

  // clamp the registers to the store geometry
  always_comb begin
    if (col_count_r == 8'd0) begin
      cols = CCNT_W'(1);
    end else if (32'(col_count_r) > MAX_COLUMNS) begin
      cols = CCNT_W'(MAX_COLUMNS);
    end else begin
      cols = CCNT_W'(col_count_r);
    end
    if (row_count_r == 7'd0) begin
      rows = RCNT_W'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows = RCNT_W'(MAX_ROWS);
    end else begin
      rows = RCNT_W'(row_count_r);
    end
  end

  // cursor pulled back inside the area in use
  assign crow_s = (RCNT_W'(crow_r) >= rows) ? ROW_W'(rows - RCNT_W'(1)) : crow_r;
  assign ccol_s = (CCNT_W'(ccol_r) >= cols) ? COL_W'(cols - CCNT_W'(1)) : ccol_r;

  assign crow_inc = RCNT_W'(crow_s) + RCNT_W'(1);
  assign ccol_inc = CCNT_W'(ccol_s) + CCNT_W'(1);
  assign row_fits = crow_inc < rows;

  assign scr_y_inc    = RCNT_W'(scr_y_r) + RCNT_W'(1);
  assign scr_last_row = scr_y_inc == rows;
  assign scr_last_col = (CCNT_W'(scr_x_r) + CCNT_W'(1)) == cols;

  assign rd_in_range = (32'(item_r.read_row) < MAX_ROWS) &&
                       (32'(item_r.read_column) < MAX_COLUMNS);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    esc_nxt       = esc_r;
    scr_y_nxt     = scr_y_r;
    scr_x_nxt     = scr_x_r;
    wipe_cnt_nxt  = wipe_cnt_r;
    wipe_resp_nxt = wipe_resp_r;
    rd_blank_nxt  = rd_blank_r;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = BLANK_CELL;
    a_row         = crow_s;
    a_col         = ccol_s;
    sweep         = 1'b0;
    is_brk        = 1'b0;
    fin           = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (item_r.op == OP_READ) begin
          // cell read, data shows up in the next cycle
          a_row        = ROW_W'(item_r.read_row);
          a_col        = COL_W'(item_r.read_column);
          ram_re       = rd_in_range;
          rd_blank_nxt = !rd_in_range;
          state_nxt    = ST_RESP;
        end else begin
          crow_nxt = crow_s;
          ccol_nxt = ccol_s;
          if (esc_r != ESC_NORMAL) begin
            if (esc_r == ESC_SEEN && ch == LBRACKET) begin
              esc_nxt = ESC_CSI;
            end else if (esc_r == ESC_CSI && (ch inside {[DIGIT_0:DIGIT_9]})) begin
              esc_nxt = ESC_CSI;
            end else begin
              esc_nxt = ESC_NORMAL;
              if (esc_r == ESC_CSI && (ch == CHAR_J || ch == CHAR_H)) begin
                // clear screen and home
                crow_nxt      = '0;
                ccol_nxt      = '0;
                wipe_cnt_nxt  = '0;
                wipe_resp_nxt = 1'b1;
                state_nxt     = ST_WIPE;
                fin           = 1'b0;
              end
            end
          end else begin
            case (ch)
              ESC_BYTE: esc_nxt  = ESC_SEEN;
              CHAR_CR:  ccol_nxt = '0;
              CHAR_LF:  is_brk   = 1'b1;
              CHAR_BS: begin
                if (ccol_s != '0) begin
                  ccol_nxt = ccol_s - COL_W'(1);
                end
              end
              default: begin
                if (ch inside {[PRINT_LO:PRINT_HI]}) begin
                  ram_we    = 1'b1;
                  ram_wdata = ch[CELL_W-1:0];
                  if (ccol_inc >= cols) begin
                    is_brk = 1'b1;
                  end else begin
                    ccol_nxt = COL_W'(ccol_inc);
                  end
                end
              end
            endcase
          end

          if (is_brk) begin
            ccol_nxt = '0;
            if (row_fits) begin
              crow_nxt = ROW_W'(crow_inc);
            end else begin
              // cursor already sits on the last row, scroll the area up
              scr_y_nxt = '0;
              scr_x_nxt = '0;
              state_nxt = ST_SCR_RD;
              fin       = 1'b0;
            end
          end

          if (fin) begin
            if (out_free) begin
              load_out  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_RESP;
            end
          end
        end
      end

      ST_SCR_RD: begin
        // fetch the cell one row below
        a_row     = ROW_W'(scr_y_inc);
        a_col     = scr_x_r;
        ram_re    = !scr_last_row;
        state_nxt = ST_SCR_WR;
      end

      ST_SCR_WR: begin
        a_row     = scr_y_r;
        a_col     = scr_x_r;
        ram_we    = 1'b1;
        ram_wdata = scr_last_row ? BLANK_CELL : ram_rdata;
        state_nxt = ST_SCR_RD;
        if (scr_last_col) begin
          scr_x_nxt = '0;
          if (scr_last_row) begin
            state_nxt = ST_RESP;
          end else begin
            scr_y_nxt = ROW_W'(scr_y_inc);
          end
        end else begin
          scr_x_nxt = scr_x_r + COL_W'(1);
        end
      end

      ST_WIPE: begin
        // blank the whole store, one cell a cycle
        sweep  = 1'b1;
        ram_we = 1'b1;
        if (wipe_cnt_r == LAST_ADDR) begin
          wipe_resp_nxt = 1'b0;
          state_nxt     = wipe_resp_r ? ST_RESP : ST_IDLE;
        end else begin
          wipe_cnt_nxt = wipe_cnt_r + ADDR_W'(1);
        end
      end

      ST_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // shared address unit
  assign ram_addr = sweep ? wipe_cnt_r
                          : ADDR_W'(32'(a_row) * MAX_COLUMNS) + ADDR_W'(a_col);

  // result beat
  always_comb begin
    if (item_r.op == OP_READ) begin
      out_nxt.cell_char = rd_blank_r ? BLANK_CELL : ram_rdata;
    end else begin
      out_nxt.cell_char = '0;
    end
    out_nxt.cursor_row    = 6'(crow_nxt);
    out_nxt.cursor_column = 7'(ccol_nxt);
    out_nxt.escape_phase  = esc_nxt;
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      crow_r      <= '0;
      ccol_r      <= '0;
      esc_r       <= ESC_NORMAL;
      scr_y_r     <= '0;
      scr_x_r     <= '0;
      wipe_cnt_r  <= '0;
      wipe_resp_r <= 1'b0;
      rd_blank_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      esc_r       <= esc_nxt;
      scr_y_r     <= scr_y_nxt;
      scr_x_r     <= scr_x_nxt;
      wipe_cnt_r  <= wipe_cnt_nxt;
      wipe_resp_r <= wipe_resp_nxt;
      rd_blank_r  <= rd_blank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= COLUMN_COUNT_RST;
      row_count_r <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: col_count_r <= cfg_wdata;
        REG_ROW_COUNT:    row_count_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule
